// ===== rtl/rprc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes of the rotator position relay controller.
package rprc_pkg;

	typedef logic [11:0]        angle_t;
	typedef logic signed [13:0] goal_t;
	typedef logic [10:0]        dead_zone_t;
	typedef logic [1:0]         path_t;
	typedef logic [1:0]         cfg_index_t;

	localparam int ANGLE_W     = 12;
	localparam int GOAL_W      = 14;
	localparam int DEAD_ZONE_W = 11;

	// Angles in tenths of a degree.
	localparam angle_t FULL_TURN = 12'd3600;
	localparam angle_t HALF_TURN = 12'd1800;
	localparam angle_t SIM_STEP  = 12'd3;
	localparam goal_t  FULL_TURN_S = 14'sd3600;

	// Request types.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_MOVE = 1'b1;

	// Path modes.
	localparam path_t PATH_SHORTEST = 2'd0;
	localparam path_t PATH_CW       = 2'd1;
	localparam path_t PATH_CCW      = 2'd2;

	// Configuration register indexes.
	localparam cfg_index_t CFG_DEAD_ZONE  = 2'd0;
	localparam cfg_index_t CFG_INVERT_CW  = 2'd1;
	localparam cfg_index_t CFG_INVERT_CCW = 2'd2;
	localparam cfg_index_t CFG_SIMULATE   = 2'd3;

endpackage

// ===== rtl/rotator_position_relay_controller.sv =====
`timescale 1ns / 1ps
// Bang-bang azimuth controller: two exclusive relay drives, goal tracking and wrap handling.
//
// The block takes one transaction per clock cycle while in_stall is low and returns exactly
// one result for each: an input register holds the request, then a single layer of
// compare-and-add logic updates azimuth, goal and the two drive flags and loads the result
// register. The state loop closes through that logic, so consecutive requests see each
// other's effect without a gap. The result register and the input register decouple the two
// sides, so a new request is taken while a finished result still waits. Configuration writes
// are taken in every cycle (cfg_ready is always high) and must only be made while no result
// is outstanding. Angles are in tenths of a degree; there is no start-up clearing period.
module rotator_position_relay_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	// Request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  rprc_pkg::angle_t          position_in,
	input  rprc_pkg::angle_t          target_in,
	input  rprc_pkg::path_t           path,
	// Result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      relay_cw,
	output logic                      relay_ccw,
	output logic                      moving_cw,
	output logic                      moving_ccw,
	output rprc_pkg::angle_t          position_out,
	output rprc_pkg::goal_t           goal_out,
	// Configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  rprc_pkg::cfg_index_t      cfg_index,
	input  rprc_pkg::dead_zone_t      cfg_data
);

	// Configuration registers
	rprc_pkg::dead_zone_t dead_zone_q;
	logic                 invert_cw_q;
	logic                 invert_ccw_q;
	logic                 simulate_q;

	// Input register
	logic                 valid_s1;
	logic                 req_type_s1;
	rprc_pkg::angle_t     position_s1;
	rprc_pkg::angle_t     target_s1;
	rprc_pkg::path_t      path_s1;

	// Controller state
	rprc_pkg::angle_t     azimuth_q;
	rprc_pkg::goal_t      goal_q;
	logic                 drive_cw_q;
	logic                 drive_ccw_q;

	// Next-state logic
	logic                 advance;
	logic                 fire;
	rprc_pkg::angle_t     target_f;
	rprc_pkg::angle_t     position_f;
	rprc_pkg::angle_t     move_diff;
	rprc_pkg::angle_t     tick_diff;
	rprc_pkg::goal_t      target_s;
	rprc_pkg::angle_t     azimuth_nxt;
	rprc_pkg::goal_t      goal_nxt;
	rprc_pkg::goal_t      azimuth_nxt_s;
	logic                 drive_cw_nxt;
	logic                 drive_ccw_nxt;

	assign cfg_ready = 1'b1;

	// The result register frees when it is empty or its content is being taken.
	assign advance  = !out_valid || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q  <= '0;
			invert_cw_q  <= 1'b0;
			invert_ccw_q <= 1'b0;
			simulate_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rprc_pkg::CFG_DEAD_ZONE:  dead_zone_q  <= cfg_data;
				rprc_pkg::CFG_INVERT_CW:  invert_cw_q  <= cfg_data[0];
				rprc_pkg::CFG_INVERT_CCW: invert_ccw_q <= cfg_data[0];
				rprc_pkg::CFG_SIMULATE:   simulate_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1 <= req_type;
			position_s1 <= position_in;
			target_s1   <= target_in;
			path_s1     <= path;
		end
	end

	assign target_f   = (target_s1 >= rprc_pkg::FULL_TURN) ? target_s1 - rprc_pkg::FULL_TURN
		: target_s1;
	assign position_f = (position_s1 >= rprc_pkg::FULL_TURN)
		? position_s1 - rprc_pkg::FULL_TURN : position_s1;
	assign move_diff  = (azimuth_q > target_f) ? azimuth_q - target_f : target_f - azimuth_q;
	assign target_s   = rprc_pkg::goal_t'({2'b00, target_f});

	always_comb begin
		azimuth_nxt   = azimuth_q;
		goal_nxt      = goal_q;
		drive_cw_nxt  = drive_cw_q;
		drive_ccw_nxt = drive_ccw_q;
		tick_diff     = '0;
		azimuth_nxt_s = '0;
		if (req_type_s1 == rprc_pkg::REQ_MOVE) begin
			goal_nxt = target_s;
			if (move_diff > {1'b0, dead_zone_q}) begin
				unique case (path_s1)
					rprc_pkg::PATH_SHORTEST: begin
						if (azimuth_q > target_f) begin
							if (move_diff < rprc_pkg::HALF_TURN) begin
								drive_cw_nxt  = 1'b0;
								drive_ccw_nxt = 1'b1;
							end else begin
								goal_nxt      = target_s + rprc_pkg::FULL_TURN_S;
								drive_cw_nxt  = 1'b1;
								drive_ccw_nxt = 1'b0;
							end
						end else begin
							if (move_diff < rprc_pkg::HALF_TURN) begin
								drive_cw_nxt  = 1'b1;
								drive_ccw_nxt = 1'b0;
							end else begin
								goal_nxt      = target_s - rprc_pkg::FULL_TURN_S;
								drive_cw_nxt  = 1'b0;
								drive_ccw_nxt = 1'b1;
							end
						end
					end
					rprc_pkg::PATH_CW: begin
						if (azimuth_q >= target_f) begin
							goal_nxt = target_s + rprc_pkg::FULL_TURN_S;
						end
						drive_cw_nxt  = 1'b1;
						drive_ccw_nxt = 1'b0;
					end
					rprc_pkg::PATH_CCW: begin
						if (azimuth_q <= target_f) begin
							goal_nxt = target_s - rprc_pkg::FULL_TURN_S;
						end
						drive_cw_nxt  = 1'b0;
						drive_ccw_nxt = 1'b1;
					end
					default: ;
				endcase
			end
		end else begin
			if (simulate_q) begin
				if (drive_cw_q) begin
					azimuth_nxt = (azimuth_q >= rprc_pkg::FULL_TURN - rprc_pkg::SIM_STEP)
						? azimuth_q - (rprc_pkg::FULL_TURN - rprc_pkg::SIM_STEP)
						: azimuth_q + rprc_pkg::SIM_STEP;
				end else if (drive_ccw_q) begin
					// An exact zero stays zero; only an underflow wraps.
					azimuth_nxt = (azimuth_q < rprc_pkg::SIM_STEP)
						? azimuth_q + (rprc_pkg::FULL_TURN - rprc_pkg::SIM_STEP)
						: azimuth_q - rprc_pkg::SIM_STEP;
				end
			end else begin
				azimuth_nxt = position_f;
			end
			// Between ticks the previous azimuth always equals the held one, so a jump of
			// more than half a turn against it marks a wrap.
			tick_diff = (azimuth_nxt > azimuth_q) ? azimuth_nxt - azimuth_q
				: azimuth_q - azimuth_nxt;
			if (tick_diff > rprc_pkg::HALF_TURN) begin
				if (goal_q > rprc_pkg::FULL_TURN_S) begin
					goal_nxt = goal_q - rprc_pkg::FULL_TURN_S;
				end else if (goal_q < 0) begin
					goal_nxt = goal_q + rprc_pkg::FULL_TURN_S;
				end
			end
			azimuth_nxt_s = rprc_pkg::goal_t'({2'b00, azimuth_nxt});
			if (drive_cw_q && (azimuth_nxt_s > goal_nxt)) begin
				drive_cw_nxt = 1'b0;
			end
			if (drive_ccw_q && (azimuth_nxt_s < goal_nxt)) begin
				drive_ccw_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			azimuth_q   <= '0;
			goal_q      <= '0;
			drive_cw_q  <= 1'b0;
			drive_ccw_q <= 1'b0;
		end else if (fire) begin
			azimuth_q   <= azimuth_nxt;
			goal_q      <= goal_nxt;
			drive_cw_q  <= drive_cw_nxt;
			drive_ccw_q <= drive_ccw_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			relay_cw     <= drive_cw_nxt ^ invert_cw_q;
			relay_ccw    <= drive_ccw_nxt ^ invert_ccw_q;
			moving_cw    <= drive_cw_nxt;
			moving_ccw   <= drive_ccw_nxt;
			position_out <= azimuth_nxt;
			goal_out     <= goal_nxt;
		end
	end

	// The two drives are never on together.
	a_drives_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(drive_cw_q && drive_ccw_q))
		else $error("both relay drives active");

	// The held azimuth stays within one turn.
	a_azimuth_range: assert property (@(posedge clk) disable iff (!arst_n)
		azimuth_q < rprc_pkg::FULL_TURN)
		else $error("azimuth out of range");

	// The extended goal stays within one turn either side.
	a_goal_range: assert property (@(posedge clk) disable iff (!arst_n)
		(goal_q >= -rprc_pkg::FULL_TURN_S) && (goal_q < rprc_pkg::FULL_TURN_S + rprc_pkg::FULL_TURN_S))
		else $error("goal out of range");

	// A transaction leaving the input register always lands in the result register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("result lost after update");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the rotator position relay controller with its own predictor.
module testbench;

	localparam int TURN_I = int'(rprc_pkg::FULL_TURN);
	localparam int HALF_I = int'(rprc_pkg::HALF_TURN);
	localparam int STEP_I = int'(rprc_pkg::SIM_STEP);
	localparam rprc_pkg::path_t PATH_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS_PER_PHASE = 120;

	typedef struct packed {
		logic             relay_cw;
		logic             relay_ccw;
		logic             moving_cw;
		logic             moving_ccw;
		rprc_pkg::angle_t position;
		logic [13:0]      goal;
	} relay_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 req_type;
	rprc_pkg::angle_t     position_in;
	rprc_pkg::angle_t     target_in;
	rprc_pkg::path_t      path;
	logic                 out_valid;
	logic                 out_stall;
	logic                 relay_cw;
	logic                 relay_ccw;
	logic                 moving_cw;
	logic                 moving_ccw;
	rprc_pkg::angle_t     position_out;
	rprc_pkg::goal_t      goal_out;
	logic                 cfg_valid;
	logic                 cfg_ready;
	rprc_pkg::cfg_index_t cfg_index;
	rprc_pkg::dead_zone_t cfg_data;

	// Predicted state of the controller and its registers, as after reset.
	int az_now = 0;
	int az_last = 0;
	int goal_ext = 0;
	bit drv_cw = 1'b0;
	bit drv_ccw = 1'b0;
	int dz_cfg = 0;
	bit inv_cw_cfg = 1'b0;
	bit inv_ccw_cfg = 1'b0;
	bit sim_cfg = 1'b1;

	relay_result_t relay_expect_q[$];
	int mismatch_count = 0;
	int items_sent = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int idle_cycles = 0;

	rotator_position_relay_controller dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int fold_angle(rprc_pkg::angle_t v);
		int a;
		a = v;
		return (a >= TURN_I) ? a - TURN_I : a;
	endfunction

	function automatic int wrap_angle(int a);
		return ((a % TURN_I) + TURN_I) % TURN_I;
	endfunction

	// Angles below 496 may also be sent in their out-of-range form, 3600 higher.
	function automatic rprc_pkg::angle_t alias_angle(int a);
		return (a < 496 && $urandom_range(0, 3) == 0) ? rprc_pkg::angle_t'(a + TURN_I)
			: rprc_pkg::angle_t'(a);
	endfunction

	function automatic rprc_pkg::path_t pick_path();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return rprc_pkg::PATH_SHORTEST;
		else if (r < 6)
			return rprc_pkg::PATH_CW;
		else if (r < 9)
			return rprc_pkg::PATH_CCW;
		return PATH_UNUSED;
	endfunction

	// Updates the predicted state for one accepted request and queues its result.
	task automatic predict_relay(logic rt, rprc_pkg::angle_t pos, rprc_pkg::angle_t tgt,
		rprc_pkg::path_t p);
		int t;
		int d;
		relay_result_t r;
		if (rt == rprc_pkg::REQ_MOVE) begin
			t = fold_angle(tgt);
			d = (az_now > t) ? az_now - t : t - az_now;
			goal_ext = t;
			if (d > dz_cfg) begin
				case (p)
					rprc_pkg::PATH_SHORTEST: begin
						if (d < HALF_I) begin
							{drv_cw, drv_ccw} = (az_now > t) ? 2'b01 : 2'b10;
						end else if (az_now > t) begin
							goal_ext = t + TURN_I;
							{drv_cw, drv_ccw} = 2'b10;
						end else begin
							goal_ext = t - TURN_I;
							{drv_cw, drv_ccw} = 2'b01;
						end
					end
					rprc_pkg::PATH_CW: begin
						goal_ext = (az_now < t) ? t : t + TURN_I;
						{drv_cw, drv_ccw} = 2'b10;
					end
					rprc_pkg::PATH_CCW: begin
						goal_ext = (az_now > t) ? t : t - TURN_I;
						{drv_cw, drv_ccw} = 2'b01;
					end
					default: begin
					end
				endcase
			end
		end else begin
			if (sim_cfg) begin
				if (drv_cw) begin
					t = az_now + STEP_I;
					az_now = (t < TURN_I) ? t : t - TURN_I;
				end
				// A step that lands exactly on 0 stays at 0.
				if (drv_ccw) begin
					t = az_now - STEP_I;
					az_now = (t >= 0) ? t : t + TURN_I;
				end
			end else begin
				az_now = fold_angle(pos);
			end
			if (az_now != az_last) begin
				d = (az_now > az_last) ? az_now - az_last : az_last - az_now;
				// Crossing the wrap point folds an extended goal back; 3600 itself is kept.
				if (d > HALF_I) begin
					if (goal_ext > TURN_I)
						goal_ext -= TURN_I;
					else if (goal_ext < 0)
						goal_ext += TURN_I;
				end
				az_last = az_now;
			end
			if (drv_cw && az_now > goal_ext)
				drv_cw = 1'b0;
			if (drv_ccw && az_now < goal_ext)
				drv_ccw = 1'b0;
		end
		r.relay_cw = drv_cw ^ inv_cw_cfg;
		r.relay_ccw = drv_ccw ^ inv_ccw_cfg;
		r.moving_cw = drv_cw;
		r.moving_ccw = drv_ccw;
		r.position = rprc_pkg::angle_t'(az_now);
		r.goal = goal_ext[13:0];
		relay_expect_q.push_back(r);
	endtask

	// Leaves in_valid high so that a following transaction can start without a gap.
	task automatic send_item(logic rt, rprc_pkg::angle_t pos, rprc_pkg::angle_t tgt,
		rprc_pkg::path_t p);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		position_in <= pos;
		target_in <= tgt;
		path <= p;
		do @(posedge clk); while (in_stall);
		items_sent++;
		predict_relay(rt, pos, tgt, p);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (relay_expect_q.size() != 0);
	endtask

	task automatic write_reg(rprc_pkg::cfg_index_t idx, rprc_pkg::dead_zone_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rprc_pkg::CFG_DEAD_ZONE:  dz_cfg = val;
			rprc_pkg::CFG_INVERT_CW:  inv_cw_cfg = val[0];
			rprc_pkg::CFG_INVERT_CCW: inv_ccw_cfg = val[0];
			rprc_pkg::CFG_SIMULATE:   sim_cfg = val[0];
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(int dz, bit icw, bit iccw, bit sim);
		drain_results();
		write_reg(rprc_pkg::CFG_DEAD_ZONE, rprc_pkg::dead_zone_t'(dz));
		write_reg(rprc_pkg::CFG_INVERT_CW, rprc_pkg::dead_zone_t'(icw));
		write_reg(rprc_pkg::CFG_INVERT_CCW, rprc_pkg::dead_zone_t'(iccw));
		write_reg(rprc_pkg::CFG_SIMULATE, rprc_pkg::dead_zone_t'(sim));
		cfg_valid <= 1'b0;
	endtask

	// Simulated stepping: equality at the goal, stopping once past it, and the step onto 0.
	task automatic test_simulated_drive();
		apply_settings(0, 1'b0, 1'b0, 1'b1);
		send_item(rprc_pkg::REQ_TICK, 12'd0, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd3, rprc_pkg::PATH_CW);
		send_item(rprc_pkg::REQ_TICK, 12'd0, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd0, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd4095, 12'd0, rprc_pkg::PATH_CCW);
		send_item(rprc_pkg::REQ_TICK, 12'd0, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd0, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd0, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd3597, PATH_UNUSED);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd3599, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd4095, 12'd4095, PATH_UNUSED);
	endtask

	// Measured positions: goal extension across the wrap, folding back, and out-of-range angles.
	task automatic test_measured_wrap();
		apply_settings(0, 1'b1, 1'b1, 1'b0);
		send_item(rprc_pkg::REQ_TICK, 12'd1800, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd3599, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd5, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd4095, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd4095, rprc_pkg::PATH_CCW);
		send_item(rprc_pkg::REQ_TICK, 12'd100, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd3500, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd495, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_TICK, 12'd494, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd3599, rprc_pkg::PATH_CW);
	endtask

	// Moves at the edge of the dead zone are ignored, just beyond it they start a drive.
	task automatic test_dead_zone();
		apply_settings(1800, 1'b0, 1'b1, 1'b0);
		send_item(rprc_pkg::REQ_TICK, 12'd0, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd1800, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd1801, rprc_pkg::PATH_CW);
		apply_settings(2047, 1'b1, 1'b0, 1'b0);
		send_item(rprc_pkg::REQ_TICK, 12'd1000, 12'd0, rprc_pkg::PATH_SHORTEST);
		send_item(rprc_pkg::REQ_MOVE, 12'd0, 12'd3047, rprc_pkg::PATH_CCW);
		send_item(rprc_pkg::REQ_TICK, 12'd2047, 12'd0, rprc_pkg::PATH_SHORTEST);
	endtask

	// Mostly a move followed by ticks that follow the drive, with some fully random noise.
	task automatic run_episode();
		int n;
		int a;
		if ($urandom_range(0, 9) < 3) begin
			send_item(1'($urandom_range(0, 1)), rprc_pkg::angle_t'($urandom_range(0, 4095)),
				rprc_pkg::angle_t'($urandom_range(0, 4095)),
				rprc_pkg::path_t'($urandom_range(0, 3)));
			return;
		end
		if (sim_cfg && $urandom_range(0, 3) != 0)
			a = wrap_angle(az_now + int'($urandom_range(0, 80)) - 40);
		else
			a = $urandom_range(0, TURN_I - 1);
		send_item(rprc_pkg::REQ_MOVE, rprc_pkg::angle_t'($urandom_range(0, 4095)),
			alias_angle(a), pick_path());
		n = $urandom_range(3, 24);
		repeat (n) begin
			if (drv_cw)
				a = az_now + int'($urandom_range(1, 60));
			else if (drv_ccw)
				a = az_now - int'($urandom_range(1, 60));
			else
				a = az_now + int'($urandom_range(0, 20)) - 10;
			send_item(rprc_pkg::REQ_TICK, alias_angle(wrap_angle(a)),
				rprc_pkg::angle_t'($urandom_range(0, 4095)),
				rprc_pkg::path_t'($urandom_range(0, 3)));
		end
	endtask

	task automatic test_random_traffic(int tx_pct, int rx_pct);
		int dz;
		int stop_at;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (3) begin
			case ($urandom_range(0, 7))
				0: dz = 0;
				1: dz = 1800;
				2: dz = 2047;
				default: dz = $urandom_range(0, 60);
			endcase
			apply_settings(dz, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			stop_at = items_sent + RANDOM_ITEMS_PER_PHASE / 3;
			while (items_sent < stop_at) begin
				run_episode();
				if ($urandom_range(0, 29) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= rprc_pkg::REQ_TICK;
		position_in <= '0;
		target_in <= '0;
		path <= rprc_pkg::PATH_SHORTEST;
		cfg_valid <= 1'b0;
		cfg_index <= rprc_pkg::CFG_DEAD_ZONE;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_simulated_drive();
		test_measured_wrap();
		test_dead_zone();
		test_random_traffic(29, 82);
		test_random_traffic(82, 29);
		test_random_traffic(0, 0);
		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	task automatic compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		relay_result_t want;
		if (out_valid && !out_stall) begin
			if (relay_expect_q.size() == 0) begin
				$error("result transaction arrived with nothing expected");
				mismatch_count++;
			end else begin
				want = relay_expect_q.pop_front();
				compare_field("relay_cw", want.relay_cw, relay_cw);
				compare_field("relay_ccw", want.relay_ccw, relay_ccw);
				compare_field("moving_cw", want.moving_cw, moving_cw);
				compare_field("moving_ccw", want.moving_ccw, moving_ccw);
				compare_field("position_out", want.position, position_out);
				compare_field("goal_out", $signed(want.goal), goal_out);
			end
		end
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		// Any transaction on any channel counts as progress.
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
